// ===== design/assert_macros.svh =====
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define FSMGR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FSMGR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fsmgr_pkg.sv =====
// shared types and constants of the frame slot manager
package fsmgr_pkg;

  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotW    = 2;
  localparam int unsigned CntW     = 3;
  localparam int unsigned DropW    = 32;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    OP_ACQ_WRITE,
    OP_ACQ_WRITE_LATEST,
    OP_COMMIT,
    OP_CANCEL,
    OP_ACQ_READ,
    OP_ACQ_NEWEST,
    OP_RELEASE,
    OP_STOP
  } op_e;

  typedef enum logic [1:0] {
    SS_FREE,
    SS_WRITING,
    SS_READY,
    SS_READING
  } slot_state_e;

  typedef enum logic [1:0] {
    RES_OK,
    RES_UNAVAIL,
    RES_STOPPED,
    RES_NOT_OWNED
  } res_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_SCAN,
    SQ_POP,
    SQ_DONE
  } seq_state_e;

  typedef struct packed {
    res_e                   status;
    logic [SlotW-1:0]       granted;
    logic [CntW-1:0]        occupancy;
    logic [CntW-1:0]        high_water;
    logic [DropW-1:0]       stale_drops;
    logic                   is_stopped;
  } result_t;

endpackage

// ===== design/frame_slot_manager.sv =====
// top level of the frame slot manager: stream ports and output register
//
// Frame slot manager. Commands arrive on the slave stream, one per transfer,
// and each command gives exactly one result transfer on the master stream.
// Slave tdata: operation (3 bits), slot (2 bits), zero fill to 8 bits.
// Master tdata: status, granted_slot, occupancy, high_water, stale_drops,
// is_stopped, from bit 0 up, zero fill to 48 bits.
// From transfer to the next s_axis_tready a command passes a decode step,
// where needed a lowest-free search (up to 4 slots) and a walk over the ring
// entries taken (one for a reclaim or a read, up to 4 for the newest-frame
// drain), and a hand-over of the result once the output register is free.
// The single slot status port of the sequencer makes both go one by one.
// The result shows on m_axis_tvalid in the cycle that s_axis_tready rises
// again. One command is worked on at a time; s_axis_tready is high only
// while the sequencer idles.
// A result waits in the output register while the receiver stalls; the next
// command is still taken and its result is held back until the register
// frees. Reset frees every slot, empties the ring and clears all counters
// and the stop flag; the block is ready right after reset.
module frame_slot_manager (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // operation [2:0], slot [4:3]
  input  logic [fsmgr_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // status [1:0], granted_slot [3:2], occupancy [6:4], high_water [9:7],
  // stale_drops [41:10], is_stopped [42]
  output logic [fsmgr_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import fsmgr_pkg::*;

  logic                 start;
  logic                 idle;
  logic                 res_valid;
  logic                 out_free;
  result_t              res;
  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_data_q;
  logic [OutDataW-1:0]  res_packed;

  assign start           = s_axis_tvalid_i & idle;
  assign s_axis_tready_o = idle;
  assign out_free        = ~m_valid_q | m_axis_tready_i;

  fsmgr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .op_i        (op_e'(s_axis_tdata_i[2:0])),
    .slot_i      (s_axis_tdata_i[4:3]),
    .out_free_i  (out_free),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // pack the result fields, lowest field first
  assign res_packed = {5'd0, res.is_stopped, res.stale_drops, res.high_water,
                       res.occupancy, res.granted, res.status};

  // output register valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid) m_valid_d = 1'b1;
    else if (m_axis_tready_i) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res_valid) m_data_q <= res_packed;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== design/fsmgr_core.sv =====
// slot pool state and the sequencer that walks slots and ring entries
module fsmgr_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  fsmgr_pkg::op_e               op_i,
  input  logic [fsmgr_pkg::SlotW-1:0]  slot_i,
  input  logic                         out_free_i,
  output logic                         idle_o,
  output logic                         res_valid_o,
  output fsmgr_pkg::result_t           res_o
);
  import fsmgr_pkg::*;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(NumSlots - 1);

  seq_state_e        state_q, state_d;
  op_e               op_q, op_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [SlotW-1:0]  scan_q, scan_d;
  slot_state_e       slot_st_q [NumSlots];
  logic [SlotW-1:0]  ring_q [NumSlots];
  logic [SlotW-1:0]  rp_q, rp_d;
  logic [SlotW-1:0]  wp_q, wp_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   peak_q, peak_d;
  logic [DropW-1:0]  drops_q, drops_d;
  logic              stop_q, stop_d;
  res_e              rstat_q, rstat_d;
  logic [SlotW-1:0]  rgrant_q, rgrant_d;

  // single status port: one address per cycle
  logic [SlotW-1:0]  ss_addr;
  slot_state_e       ss_rd;
  logic              ss_we;
  slot_state_e       ss_wdata;
  logic              ring_we;
  logic [SlotW-1:0]  ring_rd;
  logic [DropW-1:0]  drops_inc;
  logic [CntW-1:0]   count_inc;
  logic [SlotW-1:0]  rp_next;
  logic [SlotW-1:0]  wp_next;

  assign ring_rd   = ring_q[rp_q];
  assign drops_inc = (drops_q != '1) ? drops_q + DropW'(1) : drops_q;
  assign count_inc = count_q + CntW'(1);
  assign rp_next   = (rp_q == LastSlot) ? '0 : rp_q + SlotW'(1);
  assign wp_next   = (wp_q == LastSlot) ? '0 : wp_q + SlotW'(1);

  always_comb begin
    unique case (state_q)
      SQ_SCAN: ss_addr = scan_q;
      SQ_POP:  ss_addr = ring_rd;
      default: ss_addr = slot_q;
    endcase
  end
  assign ss_rd = slot_st_q[ss_addr];

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    slot_d      = slot_q;
    scan_d      = scan_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    count_d     = count_q;
    peak_d      = peak_q;
    drops_d     = drops_q;
    stop_d      = stop_q;
    rstat_d     = rstat_q;
    rgrant_d    = rgrant_q;
    ss_we       = 1'b0;
    ss_wdata    = SS_FREE;
    ring_we     = 1'b0;
    idle_o      = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      SQ_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          op_d    = op_i;
          slot_d  = slot_i;
          state_d = SQ_EXEC;
        end
      end

      SQ_EXEC: begin
        rstat_d  = RES_OK;
        rgrant_d = '0;
        state_d  = SQ_DONE;
        unique case (op_q)
          OP_ACQ_WRITE, OP_ACQ_WRITE_LATEST: begin
            if (stop_q) begin
              rstat_d = RES_STOPPED;
            end else begin
              scan_d  = '0;
              state_d = SQ_SCAN;
            end
          end
          OP_COMMIT: begin
            if (ss_rd != SS_WRITING) begin
              rstat_d = RES_NOT_OWNED;
            end else begin
              ring_we  = 1'b1;
              wp_d     = wp_next;
              ss_we    = 1'b1;
              ss_wdata = SS_READY;
              count_d  = count_inc;
              if (count_inc > peak_q) peak_d = count_inc;
            end
          end
          OP_CANCEL: begin
            if (ss_rd != SS_WRITING) begin
              rstat_d = RES_NOT_OWNED;
            end else begin
              ss_we    = 1'b1;
              ss_wdata = SS_FREE;
            end
          end
          OP_ACQ_READ: begin
            if (count_q == '0) begin
              rstat_d = stop_q ? RES_STOPPED : RES_UNAVAIL;
            end else begin
              state_d = SQ_POP;
            end
          end
          OP_ACQ_NEWEST: begin
            if (count_q == '0) begin
              rstat_d = RES_UNAVAIL;
            end else begin
              state_d = SQ_POP;
            end
          end
          OP_RELEASE: begin
            if (ss_rd != SS_READING) begin
              rstat_d = RES_NOT_OWNED;
            end else begin
              ss_we    = 1'b1;
              ss_wdata = SS_FREE;
            end
          end
          OP_STOP: begin
            stop_d = 1'b1;
          end
          default: ;
        endcase
      end

      // lowest free slot, one slot per cycle
      SQ_SCAN: begin
        if (ss_rd == SS_FREE) begin
          ss_we    = 1'b1;
          ss_wdata = SS_WRITING;
          rgrant_d = scan_q;
          state_d  = SQ_DONE;
        end else if (scan_q == LastSlot) begin
          if (op_q == OP_ACQ_WRITE_LATEST && count_q != '0) begin
            state_d = SQ_POP;
          end else begin
            rstat_d = RES_UNAVAIL;
            state_d = SQ_DONE;
          end
        end else begin
          scan_d = scan_q + SlotW'(1);
        end
      end

      // take the oldest ring entry, one per cycle
      SQ_POP: begin
        rp_d    = rp_next;
        count_d = count_q - CntW'(1);
        ss_we   = 1'b1;
        if (op_q == OP_ACQ_WRITE_LATEST) begin
          ss_wdata = SS_WRITING;
          drops_d  = drops_inc;
          rgrant_d = ring_rd;
          state_d  = SQ_DONE;
        end else if (op_q == OP_ACQ_NEWEST && count_q != CntW'(1)) begin
          ss_wdata = SS_FREE;
          drops_d  = drops_inc;
        end else begin
          ss_wdata = SS_READING;
          rgrant_d = ring_rd;
          state_d  = SQ_DONE;
        end
      end

      SQ_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = SQ_IDLE;
        end
      end

      default: state_d = SQ_IDLE;
    endcase
  end

  // result seen by the output register
  always_comb begin
    res_o.status      = rstat_q;
    res_o.granted     = (rstat_q == RES_OK) ? rgrant_q : '0;
    res_o.occupancy   = count_q;
    res_o.high_water  = peak_q;
    res_o.stale_drops = drops_q;
    res_o.is_stopped  = stop_q;
  end

  // control and pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      rp_q    <= '0;
      wp_q    <= '0;
      count_q <= '0;
      peak_q  <= '0;
      drops_q <= '0;
      stop_q  <= 1'b0;
      for (int i = 0; i < NumSlots; i++) slot_st_q[i] <= SS_FREE;
    end else begin
      state_q <= state_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      drops_q <= drops_d;
      stop_q  <= stop_d;
      if (ss_we) slot_st_q[ss_addr] <= ss_wdata;
    end
  end

  // operands, scan index, result and ring entries
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    slot_q   <= slot_d;
    scan_q   <= scan_d;
    rstat_q  <= rstat_d;
    rgrant_q <= rgrant_d;
    if (ring_we) ring_q[wp_q] <= slot_q;
  end

endmodule

// ===== design/fsmgr_checker.sv =====
// port checks of the frame slot manager and their bind
`include "assert_macros.svh"

module fsmgr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [fsmgr_pkg::InDataW-1:0]    s_axis_tdata_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [fsmgr_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import fsmgr_pkg::*;

  // a stalled result holds
  `FSMGR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  // one command at a time: no transfer right after a transfer
  `FSMGR_ASSERT(a_one_cmd, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "command taken while busy")

  // a failed command grants no slot
  `FSMGR_ASSERT(a_grant_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[1:0] != 2'(RES_OK) |-> m_axis_tdata_o[3:2] == 2'd0, "slot granted with error status")

  // occupancy never exceeds the high-water mark or the pool
  `FSMGR_ASSERT(a_occ_peak, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[6:4] <= m_axis_tdata_o[9:7] && m_axis_tdata_o[9:7] <= 3'(NumSlots), "occupancy above high water")

endmodule

bind frame_slot_manager fsmgr_checker u_fsmgr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/fsmgr_checker.sv =====
// checker for the frame slot manager: slot pool predictor and result comparison
`timescale 1ns / 1ps

module fsmgr_scoreboard (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  logic                           cmd_ready_i,
  // operation [2:0], slot [4:3]
  input  logic [fsmgr_pkg::InDataW-1:0]  cmd_data_i,
  input  logic                           res_valid_i,
  input  logic                           res_ready_i,
  // status [1:0], granted_slot [3:2], occupancy [6:4], high_water [9:7],
  // stale_drops [41:10], is_stopped [42]
  input  logic [fsmgr_pkg::OutDataW-1:0] res_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    errors_o
);
  import fsmgr_pkg::*;

  // own copy of the slot pool and the ready ring
  slot_state_e      slot_st [NumSlots];
  logic [SlotW-1:0] ring [NumSlots];
  logic [SlotW-1:0] rd_ptr;
  logic [SlotW-1:0] wr_ptr;
  logic [CntW-1:0]  n_ready;
  logic [CntW-1:0]  peak;
  logic [DropW-1:0] drops;
  logic             stopped;

  // replies owed for accepted commands, oldest first
  result_t     reply_q [$];
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;

  function automatic logic [SlotW-1:0] ring_next(logic [SlotW-1:0] p);
    return (p == SlotW'(NumSlots - 1)) ? '0 : p + 1'b1;
  endfunction

  // take the oldest ready slot off the ring
  function automatic logic [SlotW-1:0] pop_ready();
    logic [SlotW-1:0] s;
    s = ring[rd_ptr];
    rd_ptr = ring_next(rd_ptr);
    n_ready = n_ready - 1'b1;
    return s;
  endfunction

  // saturating stale frame count
  function automatic void count_stale();
    if (drops != '1) drops = drops + 1'b1;
  endfunction

  // apply one command to the pool and return the reply it gives
  function automatic result_t run_command(op_e op, logic [SlotW-1:0] idx);
    result_t r;
    int lo;
    logic [SlotW-1:0] s;
    logic owned_ok;
    r = '0;
    r.status = RES_OK;
    owned_ok = int'(idx) < NumSlots;
    case (op)
      OP_ACQ_WRITE, OP_ACQ_WRITE_LATEST: begin
        lo = -1;
        for (int k = NumSlots - 1; k >= 0; k--)
          if (slot_st[k] == SS_FREE) lo = k;
        if (stopped) begin
          r.status = RES_STOPPED;
        end else if (lo >= 0) begin
          slot_st[lo] = SS_WRITING;
          r.granted = SlotW'(lo);
        end else if (op == OP_ACQ_WRITE_LATEST && n_ready != 0) begin
          // reclaim the oldest ready frame
          s = pop_ready();
          slot_st[s] = SS_WRITING;
          r.granted = s;
          count_stale();
        end else begin
          r.status = RES_UNAVAIL;
        end
      end
      OP_COMMIT: begin
        if (!owned_ok || slot_st[idx] != SS_WRITING) begin
          r.status = RES_NOT_OWNED;
        end else begin
          ring[wr_ptr] = idx;
          wr_ptr = ring_next(wr_ptr);
          slot_st[idx] = SS_READY;
          n_ready = n_ready + 1'b1;
          if (n_ready > peak) peak = n_ready;
        end
      end
      OP_CANCEL: begin
        if (!owned_ok || slot_st[idx] != SS_WRITING) r.status = RES_NOT_OWNED;
        else slot_st[idx] = SS_FREE;
      end
      OP_ACQ_READ: begin
        if (n_ready == 0) begin
          r.status = stopped ? RES_STOPPED : RES_UNAVAIL;
        end else begin
          s = pop_ready();
          slot_st[s] = SS_READING;
          r.granted = s;
        end
      end
      OP_ACQ_NEWEST: begin
        if (n_ready == 0) begin
          r.status = RES_UNAVAIL;
        end else begin
          // drain the ring, free every frame but the newest
          s = pop_ready();
          while (n_ready != 0) begin
            slot_st[s] = SS_FREE;
            count_stale();
            s = pop_ready();
          end
          slot_st[s] = SS_READING;
          r.granted = s;
        end
      end
      OP_RELEASE: begin
        if (!owned_ok || slot_st[idx] != SS_READING) r.status = RES_NOT_OWNED;
        else slot_st[idx] = SS_FREE;
      end
      default: stopped = 1'b1;
    endcase
    if (r.status != RES_OK) r.granted = '0;
    r.occupancy   = n_ready;
    r.high_water  = peak;
    r.stale_drops = drops;
    r.is_stopped  = stopped;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // compare each result transfer, then predict each command transfer
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NumSlots; k++) begin
        slot_st[k] = SS_FREE;
        ring[k] = '0;
      end
      rd_ptr  = '0;
      wr_ptr  = '0;
      n_ready = '0;
      peak    = '0;
      drops   = '0;
      stopped = 1'b0;
      reply_q.delete();
      pending_o <= 0;
      checked_o <= 0;
      errors_o  <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        n_checked++;
        if (reply_q.size() == 0) begin
          n_errors++;
          $display("%0t: result with no command waiting, expected none, got %h",
                   $time, res_data_i);
        end else begin
          want = reply_q.pop_front();
          check_field("status", want.status, res_data_i[1:0]);
          check_field("granted_slot", want.granted, res_data_i[3:2]);
          check_field("occupancy", want.occupancy, res_data_i[6:4]);
          check_field("high_water", want.high_water, res_data_i[9:7]);
          check_field("stale_drops", want.stale_drops, res_data_i[41:10]);
          check_field("is_stopped", want.is_stopped, res_data_i[42]);
          check_field("zero fill", 0, res_data_i[OutDataW-1:43]);
        end
      end
      if (cmd_valid_i && cmd_ready_i)
        reply_q.push_back(run_command(op_e'(cmd_data_i[2:0]), cmd_data_i[4:3]));
      pending_o <= reply_q.size();
      checked_o <= n_checked;
      errors_o  <= n_errors;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the frame slot manager: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import fsmgr_pkg::*;

  logic                clk_i;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tready;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int unsigned pending;
  int unsigned checked;
  int unsigned errors;

  // idle mix of the current phase, in percent per cycle
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned n_sent = 0;

  frame_slot_manager dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  fsmgr_scoreboard u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cmd_valid_i (s_tvalid),
    .cmd_ready_i (s_tready),
    .cmd_data_i  (s_tdata),
    .res_valid_i (m_tvalid),
    .res_ready_i (m_tready),
    .res_data_i  (m_tdata),
    .pending_o   (pending),
    .checked_o   (checked),
    .errors_o    (errors)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one command transfer, with a random idle gap in front
  task automatic send_cmd(input op_e op, input logic [SlotW-1:0] s);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, s, op};
    do @(posedge clk_i); while (!s_tready);
    n_sent++;
  endtask

  // weighted operation pick: 0 balanced, 1 producer heavy, 2 consumer heavy
  function automatic op_e pick_op(int unsigned mix);
    int unsigned w [7];
    int unsigned r;
    int unsigned acc;
    r = $urandom_range(99);
    case (mix)
      0:       w = '{15, 10, 25, 7, 18, 7, 18};
      1:       w = '{25, 25, 30, 5, 5, 3, 7};
      default: w = '{15, 5, 15, 5, 25, 10, 25};
    endcase
    acc = 0;
    for (int k = 0; k < 7; k++) begin
      acc += w[k];
      if (r < acc) return op_e'(k);
    end
    return OP_RELEASE;
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty pool and ownership errors
    send_cmd(OP_ACQ_READ, 2'd0);
    send_cmd(OP_ACQ_NEWEST, 2'd0);
    send_cmd(OP_COMMIT, 2'd0);
    send_cmd(OP_CANCEL, 2'd3);
    send_cmd(OP_RELEASE, 2'd2);
    // fill the pool, then no slot for a writer
    for (int k = 0; k < 4; k++) send_cmd(OP_ACQ_WRITE, 2'd0);
    send_cmd(OP_ACQ_WRITE, 2'd1);
    send_cmd(OP_ACQ_WRITE_LATEST, 2'd2);
    // queue frames, reclaim the oldest, full ring
    send_cmd(OP_COMMIT, 2'd0);
    send_cmd(OP_COMMIT, 2'd1);
    send_cmd(OP_COMMIT, 2'd2);
    send_cmd(OP_CANCEL, 2'd3);
    send_cmd(OP_ACQ_WRITE_LATEST, 2'd0);
    send_cmd(OP_COMMIT, 2'd3);
    send_cmd(OP_ACQ_WRITE_LATEST, 2'd0);
    send_cmd(OP_COMMIT, 2'd0);
    // read, newest-frame drain, release three times, the last one not owned
    send_cmd(OP_ACQ_READ, 2'd0);
    send_cmd(OP_ACQ_NEWEST, 2'd0);
    send_cmd(OP_RELEASE, 2'd1);
    send_cmd(OP_RELEASE, 2'd0);
    send_cmd(OP_RELEASE, 2'd0);

    // random traffic over four idle mixes, stop held back for the end
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 80; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int i = 0; i < 340; i++)
        send_cmd(pick_op((i / 40) % 3), SlotW'($urandom_range(3)));
    end

    // long result hold-off while commands keep coming
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++)
      send_cmd(pick_op(1), SlotW'($urandom_range(3)));

    // bring the pool back to all free
    idle_pct = 33;
    stall_pct = 33;
    send_cmd(OP_ACQ_NEWEST, 2'd0);
    for (int k = 0; k < 4; k++) send_cmd(OP_RELEASE, SlotW'(k));
    for (int k = 0; k < 4; k++) send_cmd(OP_CANCEL, SlotW'(k));

    // stop with frames queued and a writer still busy
    for (int k = 0; k < 3; k++) send_cmd(OP_ACQ_WRITE, 2'd0);
    send_cmd(OP_COMMIT, 2'd0);
    send_cmd(OP_COMMIT, 2'd1);
    send_cmd(OP_STOP, 2'd0);
    send_cmd(OP_ACQ_WRITE, 2'd0);
    send_cmd(OP_ACQ_WRITE_LATEST, 2'd0);
    send_cmd(OP_COMMIT, 2'd2);
    send_cmd(OP_ACQ_READ, 2'd0);
    send_cmd(OP_ACQ_NEWEST, 2'd0);
    send_cmd(OP_RELEASE, 2'd0);
    send_cmd(OP_RELEASE, 2'd2);
    send_cmd(OP_ACQ_READ, 2'd0);
    send_cmd(OP_ACQ_NEWEST, 2'd0);
    send_cmd(OP_STOP, 2'd3);

    // anything goes once stopped
    for (int i = 0; i < 40; i++)
      send_cmd(op_e'($urandom_range(7)), SlotW'($urandom_range(3)));

    // drain
    s_tvalid <= 1'b0;
    stall_pct = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d commands across four idle mixes and a 400-cycle result hold-off",
             n_sent);
    $display("compared %0d results, stop and late-commit handling exercised at the end",
             checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
